// File: src/rru_pkg.sv
// package for the register rename unit
// sizes, opcode and status codes used by the rename core
// no dependencies
package rru_pkg;

    localparam int ARCH_REGS  = 32;
    localparam int PHYS_REGS  = 64;
    localparam int DATA_WIDTH = 32;

    localparam int ARCH_W    = $clog2(ARCH_REGS);
    localparam int PHYS_W    = $clog2(PHYS_REGS);
    localparam int CNT_W     = $clog2(PHYS_REGS + 1);
    localparam int FREE_INIT = PHYS_REGS - ARCH_REGS;

    typedef enum logic [2:0] {
        OP_LOOKUP  = 3'd0,
        OP_RENAME  = 3'd1,
        OP_RELEASE = 3'd2,
        OP_READ    = 3'd3,
        OP_WRITE   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

endpackage

// File: src/rru_ram.sv
// generic single-port synchronous ram with registered read data
// standalone, no package needed
module rru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/register_rename_unit_core.sv
// register rename unit: alias map, fifo free list and physical register file
// depends on rru_pkg and rru_ram
//
// An operation is taken when start is high and busy is low. Its result shows
// on phys_alias, rd_data and status for exactly one cycle with done high;
// the receiver cannot stall it. Lookup, rename, release and unused opcodes
// issue the alias map and free list ram reads on the start edge and update
// in S_MAP before done rises; read and write pass through S_PHYS as well,
// since the register file ram is addressed by the alias read from the map.
// busy falls in the done cycle, so a new operation can be started then.
// All three memories sit behind valid bits that reset clears at once
// (identity map, initial free ids, zero registers), so the unit is ready
// in the first cycle after reset with no clearing pass.
module register_rename_unit_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    opcode,
    input  logic [rru_pkg::ARCH_W-1:0]    arch_reg,
    input  logic [rru_pkg::PHYS_W-1:0]    phys_reg,
    input  logic [rru_pkg::DATA_WIDTH-1:0] wr_data,
    output logic                          done,
    output logic [rru_pkg::PHYS_W-1:0]    phys_alias,
    output logic [rru_pkg::DATA_WIDTH-1:0] rd_data,
    output logic [1:0]                    status
);

    import rru_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_PHYS
    } state_t;

    state_t                 state_reg, state_next;
    logic                   done_reg, done_next;
    logic [PHYS_W-1:0]      head_reg, head_next;
    logic [PHYS_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ARCH_REGS-1:0]   map_valid_reg, map_valid_next;
    logic [PHYS_REGS-1:0]   fifo_valid_reg, fifo_valid_next;
    logic [PHYS_REGS-1:0]   phys_valid_reg, phys_valid_next;

    op_t                    op_reg;
    logic [ARCH_W-1:0]      a_reg;
    logic [PHYS_W-1:0]      p_reg;
    logic [DATA_WIDTH-1:0]  wv_reg;
    logic [PHYS_W-1:0]      phys_addr_reg, phys_addr_next;

    logic [PHYS_W-1:0]      alias_reg, alias_next;
    logic [DATA_WIDTH-1:0]  rv_reg, rv_next;
    status_t                status_reg, status_next;

    logic                   accept;
    logic [PHYS_W-1:0]      map_q;
    logic [PHYS_W-1:0]      fifo_q;
    logic [DATA_WIDTH-1:0]  phys_q;

    logic                   map_we;
    logic [ARCH_W-1:0]      map_addr;
    logic [PHYS_W-1:0]      map_rdata;
    logic                   fifo_we;
    logic [PHYS_W-1:0]      fifo_addr;
    logic [PHYS_W-1:0]      fifo_rdata;
    logic                   phys_we;
    logic [DATA_WIDTH-1:0]  phys_rdata;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // entries never written read as their reset contents
    always_comb
    begin
        map_q = map_valid_reg[a_reg] ? map_rdata : PHYS_W'(a_reg);
        if (fifo_valid_reg[head_reg])
        begin
            fifo_q = fifo_rdata;
        end
        else if (int'(head_reg) < FREE_INIT)
        begin
            fifo_q = PHYS_W'(ARCH_REGS) + head_reg;
        end
        else
        begin
            fifo_q = '0;
        end
        phys_q = phys_valid_reg[phys_addr_reg] ? phys_rdata : '0;
    end

    // ram ports: map and free list reads issued on the start edge, updates in S_MAP
    assign map_addr  = (state_reg == S_IDLE) ? arch_reg : a_reg;
    assign map_we    = (state_reg == S_MAP) && (op_reg == OP_RENAME) && (count_reg != '0);
    assign fifo_addr = (state_reg == S_IDLE) ? head_reg : tail_reg;
    assign fifo_we   = (state_reg == S_MAP) && (op_reg == OP_RELEASE)
                       && (count_reg != CNT_W'(PHYS_REGS));
    assign phys_we   = (state_reg == S_MAP) && (op_reg == OP_WRITE);

    rru_ram #(.WIDTH(PHYS_W), .DEPTH(ARCH_REGS)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .addr  (map_addr),
        .wdata (fifo_q),
        .rdata (map_rdata)
    );

    rru_ram #(.WIDTH(PHYS_W), .DEPTH(PHYS_REGS)) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .addr  (fifo_addr),
        .wdata (p_reg),
        .rdata (fifo_rdata)
    );

    rru_ram #(.WIDTH(DATA_WIDTH), .DEPTH(PHYS_REGS)) u_phys_ram (
        .clk   (clk),
        .we    (phys_we),
        .addr  (map_q),
        .wdata (wv_reg),
        .rdata (phys_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        map_valid_next  = map_valid_reg;
        fifo_valid_next = fifo_valid_reg;
        phys_valid_next = phys_valid_reg;
        phys_addr_next  = phys_addr_reg;
        alias_next      = '0;
        rv_next         = '0;
        status_next     = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        alias_next = map_q;
                    end
                    OP_RENAME:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_BLOCKED;
                        end
                        else
                        begin
                            alias_next            = fifo_q;
                            head_next             = head_reg + PHYS_W'(1);
                            count_next            = count_reg - CNT_W'(1);
                            map_valid_next[a_reg] = 1'b1;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (count_reg == CNT_W'(PHYS_REGS))
                        begin
                            status_next = ST_DROPPED;
                        end
                        else
                        begin
                            tail_next                 = tail_reg + PHYS_W'(1);
                            count_next                = count_reg + CNT_W'(1);
                            fifo_valid_next[tail_reg] = 1'b1;
                        end
                    end
                    OP_READ, OP_WRITE:
                    begin
                        state_next     = S_PHYS;
                        done_next      = 1'b0;
                        phys_addr_next = map_q;
                        if (op_reg == OP_WRITE)
                        begin
                            phys_valid_next[map_q] = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PHYS:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (op_reg == OP_READ)
                begin
                    rv_next = phys_q;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= PHYS_W'(FREE_INIT);
            count_reg      <= CNT_W'(FREE_INIT);
            map_valid_reg  <= '0;
            fifo_valid_reg <= '0;
            phys_valid_reg <= '0;
            alias_reg      <= '0;
            rv_reg         <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            map_valid_reg  <= map_valid_next;
            fifo_valid_reg <= fifo_valid_next;
            phys_valid_reg <= phys_valid_next;
            if (done_next)
            begin
                alias_reg  <= alias_next;
                rv_reg     <= rv_next;
                status_reg <= status_next;
            end
        end
    end

    // operands of the beat in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_t'(opcode);
            a_reg  <= arch_reg;
            p_reg  <= phys_reg;
            wv_reg <= wr_data;
        end
        phys_addr_reg <= phys_addr_next;
    end

    assign done       = done_reg;
    assign phys_alias = alias_reg;
    assign rd_data    = rv_reg;
    assign status     = status_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without an operation in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PHYS_REGS))
        else $error("free list count above capacity");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg - head_reg) == count_reg[PHYS_W-1:0])
        else $error("free list pointers disagree with count");

    a_blocked_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_BLOCKED) |-> (count_reg == '0))
        else $error("rename blocked while free ids remain");

    a_dropped_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_DROPPED) |-> (count_reg == CNT_W'(PHYS_REGS)))
        else $error("release dropped while free list has room");

endmodule
